FILE: sv/ebba_pkg.sv
// Package for the edge bounding-box auto-crop block: sizes, register indexes,
// the configuration and stage structs and small helper functions.
// Depends on nothing; every other file of the block but ebba_ram uses it.
`default_nettype none

package ebba_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W = 8;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd30;
    localparam logic [DIM_W-1:0] DIM_MIN         = 11'd2;
    localparam logic [DIM_W-1:0] WIDTH_MAX       = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX      = DIM_W'(MAX_HEIGHT);

    // Effective configuration, frame size already clamped.
    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    // One pixel request on its way from the scan stage to the bounds stage.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             frame_end;
    } stage_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
            r = DIM_MIN;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        if (a > b)
            r = a - b;
        else
            r = b - a;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ebba_if.sv
// Stream interfaces of the auto-crop block: the pixel channel and the box
// channel, each with valid, ready and payload. Depends on ebba_pkg.
`default_nettype none

interface ebba_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ebba_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ebba_box_if;
    logic                       valid;
    logic                       ready;
    logic [ebba_pkg::COL_W-1:0] box_x;
    logic [ebba_pkg::ROW_W-1:0] box_y;
    logic [ebba_pkg::DIM_W-1:0] box_width;
    logic [ebba_pkg::DIM_W-1:0] box_height;
    logic                       box_found;
    logic [ebba_pkg::PIX_W-1:0] background_level;

    modport source (output valid, output box_x, output box_y, output box_width,
                    output box_height, output box_found, output background_level,
                    input ready);
    modport sink   (input valid, input box_x, input box_y, input box_width,
                    input box_height, input box_found, input background_level,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/ebba_ram.sv
// Generic single-clock RAM: one write port and one read port with a
// registered read. Depends on nothing.
`default_nettype none

module ebba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/ebba_scan.sv
// Scan stage: accepts pixels, keeps the column and row counters, issues the
// line store read and hands each pixel on to the bounds stage.
// Depends on ebba_pkg and ebba_if.
`default_nettype none

module ebba_scan (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ebba_pix_if.sink                        pixel_in,
    input  wire ebba_pkg::cfg_t             cfg,
    input  wire logic                       hold,
    output      logic                       rd_en,
    output      logic [ebba_pkg::COL_W-1:0] rd_addr,
    output      logic                       stage_valid,
    output      ebba_pkg::stage_t           stage
);

    logic [ebba_pkg::COL_W-1:0] col_reg, col_next;
    logic [ebba_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       valid_reg, valid_next;
    ebba_pkg::stage_t           stage_reg, stage_next;
    logic                       accept;
    logic                       row_end;
    logic                       frame_end;

    assign pixel_in.ready = !hold;
    assign accept         = pixel_in.valid && !hold;
    assign rd_en          = accept;
    assign rd_addr        = col_reg;

    always_comb
    begin
        row_end   = ({1'b0, col_reg} + 1'b1) >= cfg.width;
        frame_end = row_end && (({1'b0, row_reg} + 1'b1) >= cfg.height);

        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.pixel     = pixel_in.pixel_value;
            stage_next.col       = col_reg;
            stage_next.row       = row_reg;
            stage_next.row_end   = row_end;
            stage_next.frame_end = frame_end;
            valid_next           = 1'b1;
            if (!row_end)
                col_next = col_reg + 1'b1;
            else
            begin
                col_next = '0;
                if (frame_end)
                    row_next = '0;
                else
                    row_next = row_reg + 1'b1;
            end
        end
        else if (!hold)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

`default_nettype wire

FILE: sv/ebba_bounds.sv
// Bounds stage: edge tests against the left neighbour and the line store
// word, bound updates, line store write-back and the result register.
// Depends on ebba_pkg and ebba_if.
`default_nettype none

module ebba_bounds (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ebba_pkg::cfg_t             cfg,
    input  wire logic                       stage_valid,
    input  wire ebba_pkg::stage_t           stage,
    input  wire logic [ebba_pkg::PIX_W-1:0] line_word,
    output      logic                       hold,
    output      logic                       fire,
    output      logic                       wr_en,
    output      logic [ebba_pkg::COL_W-1:0] wr_addr,
    output      logic [ebba_pkg::PIX_W-1:0] wr_data,
    ebba_box_if.source                      box_out
);

    logic [ebba_pkg::PIX_W-1:0] left_pixel_reg;
    logic [ebba_pkg::DIM_W-1:0] least_left_reg, least_left_next;
    logic [ebba_pkg::COL_W-1:0] right_reg, right_next;
    logic [ebba_pkg::DIM_W-1:0] least_top_reg, least_top_next;
    logic [ebba_pkg::ROW_W-1:0] bottom_reg, bottom_next;
    logic                       seen_reg, seen_next;
    logic [ebba_pkg::PIX_W-1:0] bg_reg, bg_next;
    logic                       h_edge, v_edge;
    logic                       found;
    logic                       out_valid_reg;

    logic [ebba_pkg::COL_W-1:0] x_reg;
    logic [ebba_pkg::ROW_W-1:0] y_reg;
    logic [ebba_pkg::DIM_W-1:0] w_reg, h_reg;
    logic                       found_reg;
    logic [ebba_pkg::PIX_W-1:0] level_reg;

    // A frame-end pixel waits here while the previous result is still unread.
    assign hold    = stage_valid && stage.frame_end && out_valid_reg && !box_out.ready;
    assign fire    = stage_valid && !hold;
    assign wr_en   = fire;
    assign wr_addr = stage.col;
    assign wr_data = stage.pixel;

    always_comb
    begin
        h_edge = (stage.col != '0) &&
                 (ebba_pkg::abs_diff(stage.pixel, left_pixel_reg) > cfg.threshold);
        v_edge = (stage.row != '0) &&
                 (ebba_pkg::abs_diff(stage.pixel, line_word) > cfg.threshold);

        least_left_next = least_left_reg;
        right_next      = right_reg;
        seen_next       = seen_reg;
        bg_next         = bg_reg;
        if (h_edge)
        begin
            if ({1'b0, stage.col} < least_left_reg)
                least_left_next = {1'b0, stage.col};
            if ((stage.col - 1'b1) > right_reg)
                right_next = stage.col - 1'b1;
            if (!seen_reg)
            begin
                bg_next   = left_pixel_reg;
                seen_next = 1'b1;
            end
        end

        least_top_next = least_top_reg;
        bottom_next    = bottom_reg;
        if (v_edge)
        begin
            if ({1'b0, stage.row} < least_top_reg)
                least_top_next = {1'b0, stage.row};
            if ((stage.row - 1'b1) > bottom_reg)
                bottom_next = stage.row - 1'b1;
        end

        found = ({1'b0, right_next} > least_left_next) &&
                ({1'b0, bottom_next} > least_top_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pixel_reg <= '0;
            least_left_reg <= ebba_pkg::WIDTH_MAX;
            right_reg      <= '0;
            least_top_reg  <= ebba_pkg::HEIGHT_MAX;
            bottom_reg     <= '0;
            seen_reg       <= 1'b0;
            bg_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                left_pixel_reg <= stage.pixel;
                bg_reg         <= bg_next;
                seen_reg       <= stage.row_end ? 1'b0 : seen_next;
                if (stage.frame_end)
                begin
                    least_left_reg <= cfg.width;
                    right_reg      <= '0;
                    least_top_reg  <= cfg.height;
                    bottom_reg     <= '0;
                end
                else
                begin
                    least_left_reg <= least_left_next;
                    right_reg      <= right_next;
                    least_top_reg  <= least_top_next;
                    bottom_reg     <= bottom_next;
                end
            end
            if (fire && stage.frame_end)
                out_valid_reg <= 1'b1;
            else if (box_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && stage.frame_end)
        begin
            level_reg <= bg_next;
            found_reg <= found;
            if (found)
            begin
                x_reg <= least_left_next[ebba_pkg::COL_W-1:0];
                y_reg <= least_top_next[ebba_pkg::ROW_W-1:0];
                w_reg <= {1'b0, right_next} - least_left_next;
                h_reg <= {1'b0, bottom_next} - least_top_next;
            end
            else
            begin
                x_reg <= '0;
                y_reg <= '0;
                w_reg <= cfg.width;
                h_reg <= cfg.height;
            end
        end
    end

    assign box_out.valid            = out_valid_reg;
    assign box_out.box_x            = x_reg;
    assign box_out.box_y            = y_reg;
    assign box_out.box_width        = w_reg;
    assign box_out.box_height       = h_reg;
    assign box_out.box_found        = found_reg;
    assign box_out.background_level = level_reg;

endmodule

`default_nettype wire

FILE: sv/edge_bounding_box_autocrop.sv
// Edge bounding-box auto-crop: takes grey pixels in raster order, one per
// cycle unless held, and gives one crop box per frame at its last pixel.
//
// Channels: pixel_in carries one 8-bit pixel per request; box_out carries one
// result per frame (box_x, box_y, box_width, box_height, box_found and
// background_level). Configuration is written through cfg_wr_en, cfg_index
// and cfg_data: index 0 edge threshold, 1 frame width, 2 frame height.
// Throughput is one pixel per cycle but for the frame-end stall below, set
// by the line store, which is read when a pixel is accepted and written
// back by the bounds stage from the stage register. The result is registered
// in the bounds stage when the last pixel of a frame leaves it. While a
// result waits unread the block goes on taking pixels; only the last pixel
// of the next frame waits in the bounds stage, and pixel_in.ready drops,
// until the waiting result is taken.
// Reset clears counters, bounds and the result valid flag at once; the line
// store needs no clearing, as the first row of a frame never uses the words it reads.
// Depends on ebba_pkg, ebba_if, ebba_ram, ebba_scan and ebba_bounds.
`default_nettype none

module edge_bounding_box_autocrop (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ebba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ebba_pkg::CFG_DATA_W-1:0] cfg_data,
    ebba_pix_if.sink                             pixel_in,
    ebba_box_if.source                           box_out
);

    logic [ebba_pkg::PIX_W-1:0] threshold_reg;
    logic [ebba_pkg::DIM_W-1:0] width_reg;
    logic [ebba_pkg::DIM_W-1:0] height_reg;
    ebba_pkg::cfg_t             cfg;

    logic                       hold;
    logic                       fire;
    logic                       rd_en;
    logic [ebba_pkg::COL_W-1:0] rd_addr;
    logic                       wr_en;
    logic [ebba_pkg::COL_W-1:0] wr_addr;
    logic [ebba_pkg::PIX_W-1:0] wr_data;
    logic [ebba_pkg::PIX_W-1:0] line_word;
    logic                       stage_valid;
    ebba_pkg::stage_t           stage;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ebba_pkg::THRESHOLD_RESET;
            width_reg     <= ebba_pkg::WIDTH_MAX;
            height_reg    <= ebba_pkg::HEIGHT_MAX;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ebba_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[ebba_pkg::PIX_W-1:0];
                ebba_pkg::REG_WIDTH:     width_reg     <= cfg_data;
                ebba_pkg::REG_HEIGHT:    height_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        cfg.threshold = threshold_reg;
        cfg.width     = ebba_pkg::clamp_dim(width_reg, ebba_pkg::WIDTH_MAX);
        cfg.height    = ebba_pkg::clamp_dim(height_reg, ebba_pkg::HEIGHT_MAX);
    end

    ebba_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_in    (pixel_in),
        .cfg         (cfg),
        .hold        (hold),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    ebba_ram #(
        .WIDTH (ebba_pkg::PIX_W),
        .DEPTH (ebba_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (line_word)
    );

    ebba_bounds u_bounds (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .line_word   (line_word),
        .hold        (hold),
        .fire        (fire),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .box_out     (box_out)
    );

    // A write-back never lands on the column being read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("line store read and write collide");

    // A new result only follows a frame-end pixel leaving the bounds stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(box_out.valid) |-> $past(fire && stage.frame_end))
        else $error("result without frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (box_out.valid && box_out.box_found) |->
        (box_out.box_width != '0 && box_out.box_height != '0))
        else $error("found box has zero size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (box_out.valid && !box_out.box_found) |->
        (box_out.box_x == '0 && box_out.box_y == '0 &&
         box_out.box_width == cfg.width && box_out.box_height == cfg.height))
        else $error("missing box does not cover the frame");

endmodule

`default_nettype wire
